[src/ghe_pkg.sv]
// ----------------------------------------------------------------------------
// ghe_pkg
// Shared types and constants for the three-wire bus handshake engine.
// ----------------------------------------------------------------------------
package ghe_pkg;

    // field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned EOS_W     = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 24;

    // register reset values
    localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 16'd20;
    localparam logic [EOS_W-1:0]   EOS_RESET     = 2'd0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EOS     = 1'd1;

    // commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECV   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TMO_1  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TMO_2  = 2'd3;

    // end of string modes
    localparam logic [EOS_W-1:0] EOS_CRLF = 2'd0;
    localparam logic [EOS_W-1:0] EOS_CR   = 2'd1;
    localparam logic [EOS_W-1:0] EOS_LF   = 2'd2;
    localparam logic [EOS_W-1:0] EOS_EOI  = 2'd3;

    // terminator characters
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0a;
    localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hff;

    // handshake phase
    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_TX_NRFD  = 5'b00010,
        PH_TX_NDAC  = 5'b00100,
        PH_RX_DAVLO = 5'b01000,
        PH_RX_DAVHI = 5'b10000
    } phase_t;

endpackage

[src/gpib_handshake_engine_unit.sv]
// ----------------------------------------------------------------------------
// gpib_handshake_engine_unit
// Source and acceptor handshake engine for a three-wire parallel instrument
// bus, stepped once per bus sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one bus sample per request, with an optional command in
//   s_tuser (send or receive a byte). m_* channel: exactly one result per
//   sample, giving the pin levels to drive, busy flag, status in m_tuser and
//   received byte; m_tlast marks a byte that ends a message.
//   cfg_* channel: writes the wait limit in ms ticks (index 0) and the end of
//   string mode (index 1), always ready; write only while the block is idle.
// Timing:
//   the result is valid in the cycle after the sample is accepted; one sample
//   can be taken every cycle. The result register is the only stage, so a
//   new sample is taken whenever that register is empty or being drained.
// Reset:
//   phase idle, talker mode, all lines released, registers at their defaults
//   (timeout 20 ticks, CR LF terminator). No result is pending.
// Stall:
//   while m_tready is low and a result waits, s_tready is low and the
//   handshake state holds.
// ----------------------------------------------------------------------------
module gpib_handshake_engine_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tx_byte[7:0], tx_eoi, read_until_eoi, ms_tick, nrfd_line, ndac_line,
    // dav_line, eoi_line, atn_line, bus_data[23:16]
    input  logic [ghe_pkg::IN_DATA_W-1:0]       s_tdata,
    // command[1:0]
    input  logic [ghe_pkg::CMD_W-1:0]           s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // dio_drive[7:0], talk_mode, dav_out, eoi_out, nrfd_out, ndac_out,
    // busy_res, rx_byte[21:14], rx_eoi, rx_atn
    output logic [ghe_pkg::OUT_DATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [ghe_pkg::STATUS_W-1:0]        m_tuser,
    // rx_end
    output logic                                m_tlast,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ghe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ghe_pkg::CFG_DAT_W-1:0]       cfg_data
);

    // configuration registers
    logic [ghe_pkg::COUNT_W-1:0] timeout_reg;
    logic [ghe_pkg::EOS_W-1:0]   eos_reg;

    // handshake state
    ghe_pkg::phase_t             phase_reg, phase_next;
    logic                        talker_reg, talker_next;
    logic [ghe_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [ghe_pkg::BYTE_W-1:0]  held_byte_reg, held_byte_next;
    logic                        held_eoi_reg, held_eoi_next;
    logic                        atn_held_reg, atn_held_next;
    logic [ghe_pkg::BYTE_W-1:0]  rx_data_reg, rx_data_next;
    logic                        until_eoi_reg, until_eoi_next;
    logic                        last_cr_reg, last_cr_next;
    logic                        dav_lv_reg, dav_lv_next;
    logic                        eoi_lv_reg, eoi_lv_next;
    logic                        nrfd_lv_reg, nrfd_lv_next;
    logic                        ndac_lv_reg, ndac_lv_next;

    // result register
    logic                               out_valid_reg;
    logic [ghe_pkg::OUT_DATA_W-1:0]     out_data_reg, out_data_next;
    logic [ghe_pkg::STATUS_W-1:0]       out_status_reg, status_next;
    logic                               out_end_reg, rx_end_next;

    // unpacked sample fields
    logic [ghe_pkg::CMD_W-1:0]  cmd;
    logic [ghe_pkg::BYTE_W-1:0] tx_byte;
    logic                       tx_eoi, read_until_eoi, ms_tick;
    logic                       nrfd_line, ndac_line, dav_line, eoi_line, atn_line;
    logic [ghe_pkg::BYTE_W-1:0] bus_data;

    // timeout tracking
    logic [ghe_pkg::COUNT_W-1:0] count_inc;
    logic                        timed_out;
    logic [ghe_pkg::EOS_W-1:0]   term;
    logic [ghe_pkg::BYTE_W-1:0]  rx_byte_o;
    logic                        rx_eoi_o, rx_atn_o;
    logic                        accept;

    assign cmd            = s_tuser;
    assign tx_byte        = s_tdata[7:0];
    assign tx_eoi         = s_tdata[8];
    assign read_until_eoi = s_tdata[9];
    assign ms_tick        = s_tdata[10];
    assign nrfd_line      = s_tdata[11];
    assign ndac_line      = s_tdata[12];
    assign dav_line       = s_tdata[13];
    assign eoi_line       = s_tdata[14];
    assign atn_line       = s_tdata[15];
    assign bus_data       = s_tdata[23:16];

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // wait counter, a zero limit behaves as one
    assign count_inc = count_reg + ghe_pkg::COUNT_W'(1);
    assign timed_out = ms_tick && (count_inc >= timeout_reg);
    assign term      = until_eoi_reg ? ghe_pkg::EOS_EOI : eos_reg;

    // handshake step
    always_comb
    begin
        phase_next     = phase_reg;
        talker_next    = talker_reg;
        count_next     = count_reg;
        held_byte_next = held_byte_reg;
        held_eoi_next  = held_eoi_reg;
        atn_held_next  = atn_held_reg;
        rx_data_next   = rx_data_reg;
        until_eoi_next = until_eoi_reg;
        last_cr_next   = last_cr_reg;
        dav_lv_next    = dav_lv_reg;
        eoi_lv_next    = eoi_lv_reg;
        nrfd_lv_next   = nrfd_lv_reg;
        ndac_lv_next   = ndac_lv_reg;
        status_next    = ghe_pkg::ST_NONE;
        rx_byte_o      = '0;
        rx_eoi_o       = 1'b0;
        rx_atn_o       = 1'b0;
        rx_end_next    = 1'b0;

        case (phase_reg)
            ghe_pkg::PH_TX_NRFD:
            begin
                if (nrfd_line)
                begin
                    dav_lv_next = 1'b0;
                    phase_next  = ghe_pkg::PH_TX_NDAC;
                    count_next  = '0;
                end
                else if (ms_tick)
                begin
                    count_next = count_inc;
                    if (timed_out)
                        status_next = ghe_pkg::ST_TMO_1;
                end
            end
            ghe_pkg::PH_TX_NDAC:
            begin
                if (ndac_line)
                begin
                    dav_lv_next = 1'b1;
                    eoi_lv_next = 1'b1;
                    phase_next  = ghe_pkg::PH_IDLE;
                    count_next  = '0;
                    status_next = ghe_pkg::ST_DONE;
                end
                else if (ms_tick)
                begin
                    count_next = count_inc;
                    if (timed_out)
                        status_next = ghe_pkg::ST_TMO_2;
                end
            end
            ghe_pkg::PH_RX_DAVLO:
            begin
                if (!dav_line)
                begin
                    nrfd_lv_next  = 1'b0;
                    rx_data_next  = ~bus_data;
                    held_eoi_next = ~eoi_line;
                    atn_held_next = ~atn_line;
                    ndac_lv_next  = 1'b1;
                    phase_next    = ghe_pkg::PH_RX_DAVHI;
                    count_next    = '0;
                end
                else if (ms_tick)
                begin
                    count_next = count_inc;
                    if (timed_out)
                        status_next = ghe_pkg::ST_TMO_1;
                end
            end
            ghe_pkg::PH_RX_DAVHI:
            begin
                if (dav_line)
                begin
                    ndac_lv_next = 1'b0;
                    phase_next   = ghe_pkg::PH_IDLE;
                    count_next   = '0;
                    status_next  = ghe_pkg::ST_DONE;
                    rx_byte_o    = rx_data_reg;
                    rx_eoi_o     = held_eoi_reg;
                    rx_atn_o     = atn_held_reg;
                    // terminator rule
                    if (term == ghe_pkg::EOS_EOI && held_eoi_reg)
                    begin
                        rx_end_next = 1'b1;
                    end
                    else if (rx_data_reg == ghe_pkg::CHAR_CR)
                    begin
                        rx_end_next  = (term == ghe_pkg::EOS_CR);
                        last_cr_next = 1'b1;
                    end
                    else
                    begin
                        rx_end_next = (rx_data_reg == ghe_pkg::CHAR_LF) &&
                                      ((term == ghe_pkg::EOS_LF) ||
                                       (last_cr_reg && term == ghe_pkg::EOS_CRLF));
                        last_cr_next = 1'b0;
                    end
                    if (rx_end_next)
                        last_cr_next = 1'b0;
                end
                else if (ms_tick)
                begin
                    count_next = count_inc;
                    if (timed_out)
                        status_next = ghe_pkg::ST_TMO_2;
                end
            end
            default:
            begin
                phase_next = ghe_pkg::PH_IDLE;
                if (cmd == ghe_pkg::CMD_SEND)
                begin
                    if (!talker_reg)
                    begin
                        talker_next = 1'b1;
                        dav_lv_next = 1'b1;
                        eoi_lv_next = 1'b1;
                    end
                    held_byte_next = tx_byte;
                    if (tx_eoi)
                        eoi_lv_next = 1'b0;
                    phase_next = ghe_pkg::PH_TX_NRFD;
                    count_next = '0;
                end
                else if (cmd == ghe_pkg::CMD_RECV)
                begin
                    if (talker_reg)
                    begin
                        talker_next  = 1'b0;
                        ndac_lv_next = 1'b0;
                    end
                    nrfd_lv_next   = 1'b1;
                    until_eoi_next = read_until_eoi;
                    phase_next     = ghe_pkg::PH_RX_DAVLO;
                    count_next     = '0;
                end
            end
        endcase

        // timeout returns the pins to talker idle
        if (status_next inside {ghe_pkg::ST_TMO_1, ghe_pkg::ST_TMO_2})
        begin
            talker_next  = 1'b1;
            dav_lv_next  = 1'b1;
            eoi_lv_next  = 1'b1;
            last_cr_next = 1'b0;
            phase_next   = ghe_pkg::PH_IDLE;
            count_next   = '0;
        end
    end

    // result word from the updated state
    always_comb
    begin
        out_data_next[7:0]   = talker_next ? ~held_byte_next : ghe_pkg::BYTE_ONES;
        out_data_next[8]     = talker_next;
        out_data_next[9]     = talker_next ? dav_lv_next : 1'b1;
        out_data_next[10]    = talker_next ? eoi_lv_next : 1'b1;
        out_data_next[11]    = talker_next ? 1'b1 : nrfd_lv_next;
        out_data_next[12]    = talker_next ? 1'b1 : ndac_lv_next;
        out_data_next[13]    = (phase_next != ghe_pkg::PH_IDLE);
        out_data_next[21:14] = rx_byte_o;
        out_data_next[22]    = rx_eoi_o;
        out_data_next[23]    = rx_atn_o;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= ghe_pkg::TIMEOUT_RESET;
            eos_reg     <= ghe_pkg::EOS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ghe_pkg::REG_TIMEOUT)
                timeout_reg <= cfg_data;
            else if (cfg_index == ghe_pkg::REG_EOS)
                eos_reg <= cfg_data[ghe_pkg::EOS_W-1:0];
        end
    end

    // handshake state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ghe_pkg::PH_IDLE;
            talker_reg    <= 1'b1;
            count_reg     <= '0;
            held_byte_reg <= '0;
            held_eoi_reg  <= 1'b0;
            atn_held_reg  <= 1'b0;
            rx_data_reg   <= '0;
            until_eoi_reg <= 1'b0;
            last_cr_reg   <= 1'b0;
            dav_lv_reg    <= 1'b1;
            eoi_lv_reg    <= 1'b1;
            nrfd_lv_reg   <= 1'b1;
            ndac_lv_reg   <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            talker_reg    <= talker_next;
            count_reg     <= count_next;
            held_byte_reg <= held_byte_next;
            held_eoi_reg  <= held_eoi_next;
            atn_held_reg  <= atn_held_next;
            rx_data_reg   <= rx_data_next;
            until_eoi_reg <= until_eoi_next;
            last_cr_reg   <= last_cr_next;
            dav_lv_reg    <= dav_lv_next;
            eoi_lv_reg    <= eoi_lv_next;
            nrfd_lv_reg   <= nrfd_lv_next;
            ndac_lv_reg   <= ndac_lv_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= status_next;
            out_end_reg    <= rx_end_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_end_reg;

    // a finished or timed out transfer leaves the block idle
    a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ghe_pkg::ST_NONE) |-> !m_tdata[13])
        else $error("busy flag set with a transfer event");

    // a timeout returns to talker mode
    a_timeout_talker: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ghe_pkg::ST_TMO_1 || m_tuser == ghe_pkg::ST_TMO_2))
        |-> (m_tdata[8] && m_tdata[9] && m_tdata[10]))
        else $error("timeout did not release talker lines");

    // end of message only on a completed byte
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == ghe_pkg::ST_DONE && !m_tdata[8]))
        else $error("end of message outside a received byte");

    // listener mode drives no data
    a_listen_dio: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] == ghe_pkg::BYTE_ONES))
        else $error("listener drives data lines");

endmodule
